FILE: src/dpd_pkg.sv
// shared constants and helpers for the debug packet deframer
package dpd_pkg;

	localparam int unsigned LIMIT_W = 12;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned EVENT_W = 3;
	localparam int unsigned PHASE_W = 3;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd1023;

	localparam logic [PHASE_W-1:0] PH_HUNT = 3'd0;
	localparam logic [PHASE_W-1:0] PH_DATA = 3'd1;
	localparam logic [PHASE_W-1:0] PH_ESC  = 3'd2;
	localparam logic [PHASE_W-1:0] PH_CK1  = 3'd3;
	localparam logic [PHASE_W-1:0] PH_CK2  = 3'd4;

	localparam logic [EVENT_W-1:0] EV_NONE     = 3'd0;
	localparam logic [EVENT_W-1:0] EV_BYTE     = 3'd1;
	localparam logic [EVENT_W-1:0] EV_GOOD     = 3'd2;
	localparam logic [EVENT_W-1:0] EV_BAD      = 3'd3;
	localparam logic [EVENT_W-1:0] EV_INT_IDLE = 3'd4;
	localparam logic [EVENT_W-1:0] EV_INT_PKT  = 3'd5;
	localparam logic [EVENT_W-1:0] EV_OVERFLOW = 3'd6;
	localparam logic [EVENT_W-1:0] EV_STRAY    = 3'd7;

	localparam logic [BYTE_W-1:0] CH_START  = 8'h24;
	localparam logic [BYTE_W-1:0] CH_END    = 8'h23;
	localparam logic [BYTE_W-1:0] CH_BINARY = 8'h58;
	localparam logic [BYTE_W-1:0] CH_ESCAPE = 8'h7d;
	localparam logic [BYTE_W-1:0] CH_XORVAL = 8'h20;
	localparam logic [BYTE_W-1:0] CH_INTR   = 8'h03;
	localparam logic [BYTE_W-1:0] CH_ACK    = 8'h2b;
	localparam logic [BYTE_W-1:0] CH_NAK    = 8'h2d;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_digit_t;

	function automatic hex_digit_t hex_decode(input logic [BYTE_W-1:0] c);
		hex_digit_t r;
		r.ok  = 1'b1;
		r.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.val = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r.val = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r.val = 4'(c - 8'h37);
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

	function automatic logic [BYTE_W-1:0] checksum_value(input logic [BYTE_W-1:0] c1,
			input logic [BYTE_W-1:0] c2);
		hex_digit_t h1;
		hex_digit_t h2;
		logic [BYTE_W-1:0] v;
		h1 = hex_decode(c1);
		h2 = hex_decode(c2);
		v  = '0;
		if (h1.ok) begin
			v = {4'd0, h1.val};
			if (h2.ok) begin
				v = {h1.val, h2.val};
			end
		end
		return v;
	endfunction

endpackage

FILE: src/debug_packet_deframer_top.sv
// Remote serial debug link packet deframer. Received characters enter on the
// s_axis side one per request; every accepted character gives exactly one
// result request on the m_axis side, carrying an event code, the unescaped
// payload byte, the payload length at packet end and the binary packet flag.
// A character passes through the input register, then the result register;
// a new character is taken every cycle as long as the output side takes
// results. The framing state (phase, running checksum, byte count) is updated
// combinationally between the two registers, which allows that rate.
// The user must write payload_limit through cfg_wr_en and cfg_wr_data only
// while the block is idle (not enforced by the block); it resets to 1023.
module debug_packet_deframer_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [dpd_pkg::LIMIT_W-1:0]    cfg_wr_data,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,   // rx_byte
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [23:0]                    m_axis_tdata,   // payload_byte, packet_length, zero pad
	output logic [3:0]                     m_axis_tuser    // event_res, binary_packet
);
	import dpd_pkg::*;

	logic [LIMIT_W-1:0] limit_q;
	logic [PHASE_W-1:0] phase_q;
	logic [BYTE_W-1:0]  sum_q;
	logic [LIMIT_W-1:0] count_q;
	logic               escape_q;
	logic               type_seen_q;
	logic [BYTE_W-1:0]  first_digit_q;

	logic               valid_s1;
	logic [BYTE_W-1:0]  rx_s1;

	logic               out_valid_q;
	logic [EVENT_W-1:0] event_q;
	logic [BYTE_W-1:0]  pbyte_q;
	logic [LIMIT_W-1:0] length_q;
	logic               binary_q;

	logic               out_free;
	logic               advance;

	logic [PHASE_W-1:0] n_phase;
	logic [BYTE_W-1:0]  n_sum;
	logic [LIMIT_W-1:0] n_count;
	logic               n_escape;
	logic               n_type_seen;
	logic [BYTE_W-1:0]  n_first_digit;
	logic [EVENT_W-1:0] n_event;
	logic [BYTE_W-1:0]  n_pbyte;
	logic [LIMIT_W-1:0] n_length;
	logic               do_store;
	logic [BYTE_W-1:0]  store_val;
	logic [LIMIT_W:0]   next_count;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, length_q, pbyte_q};
	assign m_axis_tuser  = {binary_q, event_q};

	assign next_count = {1'b0, count_q} + {{LIMIT_W{1'b0}}, 1'b1};

	always_comb begin
		n_phase       = phase_q;
		n_sum         = sum_q;
		n_count       = count_q;
		n_escape      = escape_q;
		n_type_seen   = type_seen_q;
		n_first_digit = first_digit_q;
		n_event       = EV_NONE;
		n_pbyte       = '0;
		n_length      = '0;
		do_store      = 1'b0;
		store_val     = rx_s1;
		unique case (phase_q)
			PH_DATA: begin
				if (!type_seen_q) begin
					n_type_seen = 1'b1;
					n_escape    = (rx_s1 == CH_BINARY);
				end
				if (rx_s1 == CH_END) begin
					n_phase = PH_CK1;
				end else if (n_escape && rx_s1 == CH_ESCAPE) begin
					n_sum   = sum_q + rx_s1;
					n_phase = PH_ESC;
				end else if (!n_escape && rx_s1 == CH_INTR) begin
					n_event = EV_INT_PKT;
				end else begin
					n_sum    = sum_q + rx_s1;
					do_store = 1'b1;
				end
			end
			PH_ESC: begin
				n_sum     = sum_q + rx_s1;
				n_phase   = PH_DATA;
				do_store  = 1'b1;
				store_val = rx_s1 ^ CH_XORVAL;
			end
			PH_CK1: begin
				n_first_digit = rx_s1;
				n_phase       = PH_CK2;
			end
			PH_CK2: begin
				n_event  = (checksum_value(first_digit_q, rx_s1) == sum_q) ? EV_GOOD : EV_BAD;
				n_length = count_q;
				n_phase  = PH_HUNT;
			end
			default: begin
				n_phase = PH_HUNT;
				if (rx_s1 == CH_START) begin
					n_phase     = PH_DATA;
					n_sum       = '0;
					n_count     = '0;
					n_type_seen = 1'b0;
					n_escape    = 1'b0;
				end else if (rx_s1 == CH_ACK || rx_s1 == CH_NAK) begin
					n_event = EV_STRAY;
				end else if (rx_s1 == CH_INTR) begin
					n_event = EV_INT_IDLE;
				end
			end
		endcase
		if (do_store) begin
			if (next_count > {1'b0, limit_q}) begin
				n_phase = PH_HUNT;
				n_event = EV_OVERFLOW;
			end else begin
				n_count = next_count[LIMIT_W-1:0];
				n_pbyte = store_val;
				n_event = EV_BYTE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			rx_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HUNT;
			sum_q         <= '0;
			count_q       <= '0;
			escape_q      <= 1'b0;
			type_seen_q   <= 1'b0;
			first_digit_q <= '0;
		end else if (advance) begin
			phase_q       <= n_phase;
			sum_q         <= n_sum;
			count_q       <= n_count;
			escape_q      <= n_escape;
			type_seen_q   <= n_type_seen;
			first_digit_q <= n_first_digit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_q  <= n_event;
			pbyte_q  <= n_pbyte;
			length_q <= n_length;
			binary_q <= n_escape;
		end
	end

endmodule

FILE: tb/tb_debug_packet_deframer_top.sv
// testbench for the debug packet deframer: directed and random byte streams checked against a predictor
`timescale 1ns / 100ps

module tb_debug_packet_deframer_top;
	import dpd_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_CYCLES = 200;

	typedef struct packed {
		logic [EVENT_W-1:0] ev;
		logic [BYTE_W-1:0]  pbyte;
		logic [LIMIT_W-1:0] plen;
		logic               bin;
	} deframe_res_t;

	typedef struct packed {
		logic [BYTE_W-1:0] rx;
		logic              fixed;
		deframe_res_t      want;
	} dir_row_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [LIMIT_W-1:0]  cfg_wr_data;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [7:0]          s_axis_tdata;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [23:0]         m_axis_tdata;
	logic [3:0]          m_axis_tuser;

	// predictor state
	logic [PHASE_W-1:0]  fr_phase;
	logic [BYTE_W-1:0]   fr_sum;
	logic [LIMIT_W-1:0]  fr_count;
	logic                fr_bin;
	logic                fr_type_seen;
	logic [BYTE_W-1:0]   fr_digit1;
	logic [LIMIT_W-1:0]  fr_limit;

	deframe_res_t want_q[$];
	int  err_cnt = 0;
	int  sent_cnt = 0;
	int  cycle_cnt = 0;
	bit  src_idle_on;
	bit  snk_idle_on;
	bit  hold_req;

	dir_row_t dir_rows [0:23] = '{
		'{CH_ACK,    1'b1, '{EV_STRAY,    8'h00, 12'd0, 1'b0}},
		'{CH_NAK,    1'b1, '{EV_STRAY,    8'h00, 12'd0, 1'b0}},
		'{CH_INTR,   1'b1, '{EV_INT_IDLE, 8'h00, 12'd0, 1'b0}},
		'{8'hff,     1'b1, '{EV_NONE,     8'h00, 12'd0, 1'b0}},
		'{8'h00,     1'b1, '{EV_NONE,     8'h00, 12'd0, 1'b0}},
		'{CH_START,  1'b1, '{EV_NONE,     8'h00, 12'd0, 1'b0}},
		'{8'h61,     1'b1, '{EV_BYTE,     8'h61, 12'd0, 1'b0}},
		'{CH_INTR,   1'b1, '{EV_INT_PKT,  8'h00, 12'd0, 1'b0}},
		'{CH_START,  1'b1, '{EV_BYTE,     8'h24, 12'd0, 1'b0}},
		'{CH_END,    1'b1, '{EV_NONE,     8'h00, 12'd0, 1'b0}},
		'{8'h38,     1'b1, '{EV_NONE,     8'h00, 12'd0, 1'b0}},
		'{8'h35,     1'b1, '{EV_GOOD,     8'h00, 12'd2, 1'b0}},
		'{CH_START,  1'b1, '{EV_NONE,     8'h00, 12'd0, 1'b0}},
		'{CH_BINARY, 1'b1, '{EV_BYTE,     8'h58, 12'd0, 1'b1}},
		'{CH_ESCAPE, 1'b1, '{EV_NONE,     8'h00, 12'd0, 1'b1}},
		'{CH_END,    1'b1, '{EV_BYTE,     8'h03, 12'd0, 1'b1}},
		'{CH_INTR,   1'b1, '{EV_BYTE,     8'h03, 12'd0, 1'b1}},
		'{CH_END,    1'b1, '{EV_NONE,     8'h00, 12'd0, 1'b1}},
		'{8'h46,     1'b1, '{EV_NONE,     8'h00, 12'd0, 1'b1}},
		'{8'h7a,     1'b0, '{EV_NONE,     8'h00, 12'd0, 1'b0}},
		'{CH_START,  1'b1, '{EV_NONE,     8'h00, 12'd0, 1'b0}},
		'{CH_END,    1'b1, '{EV_NONE,     8'h00, 12'd0, 1'b0}},
		'{8'h67,     1'b1, '{EV_NONE,     8'h00, 12'd0, 1'b0}},
		'{8'h30,     1'b1, '{EV_GOOD,     8'h00, 12'd0, 1'b0}}
	};

	debug_packet_deframer_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int hex_nibble(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return int'(c) - 48;
		if (c >= 8'h61 && c <= 8'h66) return int'(c) - 87;
		if (c >= 8'h41 && c <= 8'h46) return int'(c) - 55;
		return -1;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10) return 8'h30 + 8'(nib);
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
	endfunction

	function automatic void count_payload(input logic [7:0] b, inout deframe_res_t r);
		if ({1'b0, fr_count} + 13'd1 > {1'b0, fr_limit}) begin
			fr_phase = PH_HUNT;
			r.ev = EV_OVERFLOW;
		end else begin
			fr_count = fr_count + 12'd1;
			r.pbyte = b;
			r.ev = EV_BYTE;
		end
	endfunction

	function automatic deframe_res_t deframe_predict(input logic [7:0] c);
		deframe_res_t r;
		int h1;
		int h2;
		logic [7:0] ck;
		r = '0;
		case (fr_phase)
			PH_DATA: begin
				if (!fr_type_seen) begin
					fr_type_seen = 1'b1;
					fr_bin = (c == CH_BINARY);
				end
				if (c == CH_END) begin
					fr_phase = PH_CK1;
				end else if (fr_bin && c == CH_ESCAPE) begin
					fr_sum = fr_sum + c;
					fr_phase = PH_ESC;
				end else if (!fr_bin && c == CH_INTR) begin
					r.ev = EV_INT_PKT;
				end else begin
					fr_sum = fr_sum + c;
					count_payload(c, r);
				end
			end
			PH_ESC: begin
				fr_sum = fr_sum + c;
				fr_phase = PH_DATA;
				count_payload(c ^ CH_XORVAL, r);
			end
			PH_CK1: begin
				fr_digit1 = c;
				fr_phase = PH_CK2;
			end
			PH_CK2: begin
				h1 = hex_nibble(fr_digit1);
				h2 = hex_nibble(c);
				ck = '0;
				if (h1 >= 0) begin
					ck = 8'(h1);
					if (h2 >= 0) ck = 8'(h1 * 16 + h2);
				end
				r.ev = (ck == fr_sum) ? EV_GOOD : EV_BAD;
				r.plen = fr_count;
				fr_phase = PH_HUNT;
			end
			default: begin
				fr_phase = PH_HUNT;
				if (c == CH_START) begin
					fr_phase = PH_DATA;
					fr_sum = '0;
					fr_count = '0;
					fr_type_seen = 1'b0;
					fr_bin = 1'b0;
				end else if (c == CH_ACK || c == CH_NAK) begin
					r.ev = EV_STRAY;
				end else if (c == CH_INTR) begin
					r.ev = EV_INT_IDLE;
				end
			end
		endcase
		r.bin = fr_bin;
		return r;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic use_given = 1'b0,
			input deframe_res_t given = '0);
		deframe_res_t r;
		if (src_idle_on && $urandom_range(0, 9) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		r = deframe_predict(b);
		want_q.push_back(use_given ? given : r);
		sent_cnt++;
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (want_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] v);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		fr_limit = v;
	endtask

	task automatic send_packet();
		int n;
		int form;
		bit bin;
		logic [7:0] ck;
		bin = ($urandom_range(0, 2) == 0);
		n = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 6);
		send_byte(CH_START);
		if (n > 0) send_byte(bin ? CH_BINARY : 8'($urandom_range(0, 255)));
		for (int i = 1; i < n; i++) begin
			case ($urandom_range(0, 9))
				0: begin
					send_byte(CH_ESCAPE);
					if (bin) begin
						case ($urandom_range(0, 4))
							0: send_byte(CH_END);
							1: send_byte(CH_START);
							2: send_byte(CH_ESCAPE);
							3: send_byte(CH_INTR);
							default: send_byte(8'($urandom_range(0, 255)));
						endcase
					end
				end
				1: send_byte(CH_INTR);
				2: send_byte(CH_START);
				default: send_byte(8'($urandom_range(0, 255)));
			endcase
		end
		send_byte(CH_END);
		ck = fr_sum;
		form = $urandom_range(0, 19);
		if (form < 14) begin
			send_byte(hex_char(ck[7:4]));
			send_byte(hex_char(ck[3:0]));
		end else if (form < 17) begin
			send_byte(hex_char(4'($urandom)));
			send_byte(hex_char(4'($urandom)));
		end else if (form < 19) begin
			send_byte(hex_char(ck[3:0]));
			send_byte(8'($urandom_range(0, 255)));
		end else begin
			send_byte(8'($urandom_range(0, 255)));
			send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic run_traffic(input int n_items);
		int stop_at;
		stop_at = sent_cnt + n_items;
		while (sent_cnt < stop_at) begin
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 3)) begin
					case ($urandom_range(0, 3))
						0: send_byte(CH_ACK);
						1: send_byte(CH_NAK);
						2: send_byte(CH_INTR);
						default: send_byte(8'($urandom_range(0, 255)));
					endcase
				end
			end
			send_packet();
		end
	endtask

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			if (err_cnt < 40) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
			end
			err_cnt++;
		end
	endtask

	always @(posedge clk) begin : result_check
		deframe_res_t w;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (want_q.size() == 0) begin
				if (err_cnt < 40) begin
					$display("%0t: unexpected result, expected none, actual %0h/%0h", $time,
						m_axis_tuser, m_axis_tdata);
				end
				err_cnt++;
			end else begin
				w = want_q.pop_front();
				check_field("event", int'(w.ev), int'(m_axis_tuser[2:0]));
				check_field("payload_byte", int'(w.pbyte), int'(m_axis_tdata[7:0]));
				check_field("packet_length", int'(w.plen), int'(m_axis_tdata[19:8]));
				check_field("binary_packet", int'(w.bin), int'(m_axis_tuser[3]));
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// result side pacing, with one long hold on request
	initial begin : sink_pace
		m_axis_tready <= 1'b0;
		forever begin
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (snk_idle_on && $urandom_range(0, 7) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		src_idle_on = 1'b1;
		snk_idle_on = 1'b1;
		hold_req = 1'b0;
		fr_phase = PH_HUNT;
		fr_sum = '0;
		fr_count = '0;
		fr_bin = 1'b0;
		fr_type_seen = 1'b0;
		fr_digit1 = '0;
		fr_limit = LIMIT_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) send_byte(dir_rows[i].rx, dir_rows[i].fixed, dir_rows[i].want);

		run_traffic(250);
		hold_req = 1'b1;
		run_traffic(100);
		write_limit(12'd1);
		run_traffic(200);
		write_limit(12'd4095);
		run_traffic(200);
		write_limit(12'($urandom_range(2, 12)));
		run_traffic(250);

		// no idling from here on
		wait_drained();
		src_idle_on = 1'b0;
		snk_idle_on = 1'b0;
		write_limit(LIMIT_RESET);
		run_traffic(350);

		wait_drained();
		repeat (10) @(posedge clk);
		if (err_cnt == 0 && want_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
